// ----- sv/wtr_pkg.sv -----
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared types, byte codes and the microcode ROM of the byte converter.
// ----------------------------------------------------------------------------
package wtr_pkg;

    localparam int PC_W = 6;

    // Document byte codes
    localparam logic [7:0] CODE_ESC      = 8'h05;
    localparam logic [7:0] CODE_LF       = 8'h0A;
    localparam logic [7:0] CODE_CR       = 8'h0D;
    localparam logic [7:0] CODE_EOD      = 8'h1A;
    localparam logic [7:0] CODE_SOFT_CR  = 8'h8A;
    localparam logic [7:0] CODE_FILL     = 8'hFF;
    localparam logic [7:0] CODE_SOFT_SP  = 8'h90;
    localparam logic [7:0] CODE_BOLD     = 8'hE2;
    localparam logic [7:0] CODE_ITALIC   = 8'hE9;
    localparam logic [7:0] CODE_ULINE    = 8'hF5;
    localparam logic [7:0] CODE_SUB      = 8'hF3;
    localparam logic [7:0] CODE_SUPER    = 8'hF4;
    localparam logic [7:0] CODE_LARGE    = 8'hEC;
    localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
    localparam logic [7:0] CHAR_BSLASH   = 8'h5C;

    // Format flag bit positions
    localparam logic [2:0] FLG_BOLD   = 3'd0;
    localparam logic [2:0] FLG_ITALIC = 3'd1;
    localparam logic [2:0] FLG_ULINE  = 3'd2;
    localparam logic [2:0] FLG_SUB    = 3'd3;
    localparam logic [2:0] FLG_SUPER  = 3'd4;
    localparam logic [2:0] FLG_LARGE  = 3'd5;

    // Program entry points
    localparam logic [PC_W-1:0] PC_FMT    = 6'd0;
    localparam logic [PC_W-1:0] PC_FS24   = 6'd29;
    localparam logic [PC_W-1:0] PC_PAR    = 6'd25;
    localparam logic [PC_W-1:0] PC_ESC    = 6'd35;
    localparam logic [PC_W-1:0] PC_PASS   = 6'd37;
    localparam logic [PC_W-1:0] PC_STATUS = 6'd38;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_BYTE,
        SRC_STATUS
    } src_t;

    typedef struct packed {
        src_t             src;
        logic [7:0]       lit;
        logic             test_en;   // skip to target when the flag is clear
        logic [2:0]       test_bit;
        logic [PC_W-1:0]  target;
        logic             last;
    } uword_t;

    typedef struct packed {
        logic             go;
        logic [PC_W-1:0]  pc;
        logic [7:0]       in_byte;
    } seq_start_t;

    function automatic uword_t lit(input logic [7:0] c, input logic last);
        uword_t w;
        w.src      = SRC_LIT;
        w.lit      = c;
        w.test_en  = 1'b0;
        w.test_bit = FLG_BOLD;
        w.target   = '0;
        w.last     = last;
        return w;
    endfunction

    function automatic uword_t tst(input logic [2:0] b, input logic [PC_W-1:0] t);
        uword_t w;
        w          = lit(CHAR_BSLASH, 1'b0);
        w.test_en  = 1'b1;
        w.test_bit = b;
        w.target   = t;
        return w;
    endfunction

    function automatic uword_t uc_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        w     = lit(8'h00, 1'b1);
        w.src = SRC_STATUS;
        unique case (addr)
            // \plain
            6'd0:  w = lit(CHAR_BSLASH, 1'b0);
            6'd1:  w = lit("p", 1'b0);
            6'd2:  w = lit("l", 1'b0);
            6'd3:  w = lit("a", 1'b0);
            6'd4:  w = lit("i", 1'b0);
            6'd5:  w = lit("n", 1'b0);
            // active flags
            6'd6:  w = tst(FLG_BOLD, 6'd8);
            6'd7:  w = lit("b", 1'b0);
            6'd8:  w = tst(FLG_ITALIC, 6'd10);
            6'd9:  w = lit("i", 1'b0);
            6'd10: w = tst(FLG_ULINE, 6'd13);
            6'd11: w = lit("u", 1'b0);
            6'd12: w = lit("l", 1'b0);
            6'd13: w = tst(FLG_SUB, 6'd16);
            6'd14: w = lit("d", 1'b0);
            6'd15: w = lit("n", 1'b0);
            6'd16: w = tst(FLG_SUPER, 6'd19);
            6'd17: w = lit("u", 1'b0);
            6'd18: w = lit("p", 1'b0);
            6'd19: w = tst(FLG_LARGE, PC_FS24);
            6'd20: w = lit("f", 1'b0);
            6'd21: w = lit("s", 1'b0);
            6'd22: w = lit("2", 1'b0);
            6'd23: w = lit("8", 1'b0);
            6'd24: w = lit(" ", 1'b1);
            // \par then falls into \fs24
            6'd25: w = lit(CHAR_BSLASH, 1'b0);
            6'd26: w = lit("p", 1'b0);
            6'd27: w = lit("a", 1'b0);
            6'd28: w = lit("r", 1'b0);
            6'd29: w = lit(CHAR_BSLASH, 1'b0);
            6'd30: w = lit("f", 1'b0);
            6'd31: w = lit("s", 1'b0);
            6'd32: w = lit("2", 1'b0);
            6'd33: w = lit("4", 1'b0);
            6'd34: w = lit(" ", 1'b1);
            // escaped special character
            6'd35: w = lit(CHAR_BSLASH, 1'b0);
            6'd36: begin
                w     = lit(8'h00, 1'b1);
                w.src = SRC_BYTE;
            end
            6'd37: begin
                w     = lit(8'h00, 1'b1);
                w.src = SRC_BYTE;
            end
            default: begin
                w     = lit(8'h00, 1'b1);
                w.src = SRC_STATUS;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/wordproc_to_rtf_byte_converter.sv -----
// A run's first result byte is registered once the start address is in the
// sequencer's program counter. No input is taken while a run is busy; a
// format run is up to 25 result bytes. The sequencer emits one byte per step
// unless the output stalls; a clear flag test emits nothing and skips ahead.
// Reset (aresetn low, synchronous) clears mode, escape, flags and sequencer.
// ----------------------------------------------------------------------------
// wordproc_to_rtf_byte_converter
// Converts word processor document bytes to RTF markup or plain text.
// ----------------------------------------------------------------------------
module wordproc_to_rtf_byte_converter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_plain_text_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_unknown_code,
    output logic       m_last_of_run
);

    logic                 mode_reg;
    logic                 esc_reg, esc_next;
    logic [5:0]           flags_reg, flags_next;
    logic [5:0]           toggle;
    logic                 busy;
    logic                 accept;
    wtr_pkg::seq_start_t  start;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;

    always_comb begin
        unique case (s_in_byte)
            wtr_pkg::CODE_BOLD:   toggle = 6'b000001;
            wtr_pkg::CODE_ITALIC: toggle = 6'b000010;
            wtr_pkg::CODE_ULINE:  toggle = 6'b000100;
            wtr_pkg::CODE_SUB:    toggle = 6'b001000;
            wtr_pkg::CODE_SUPER:  toggle = 6'b010000;
            wtr_pkg::CODE_LARGE:  toggle = 6'b100000;
            default:              toggle = 6'b000000;
        endcase
    end

    always_comb begin
        esc_next      = esc_reg;
        flags_next    = flags_reg;
        start.go      = 1'b0;
        start.pc      = wtr_pkg::PC_PASS;
        start.in_byte = s_in_byte;
        if (accept) begin
            if (esc_reg) begin
                esc_next = 1'b0;
                if (!mode_reg) begin
                    if (toggle != 6'b000000) begin
                        flags_next = flags_reg ^ toggle;
                        start.go   = 1'b1;
                        start.pc   = wtr_pkg::PC_FMT;
                    end else if (s_in_byte != wtr_pkg::CODE_SOFT_SP) begin
                        start.go = 1'b1;
                        start.pc = wtr_pkg::PC_STATUS;
                    end
                end
            end else begin
                unique case (s_in_byte)
                    wtr_pkg::CODE_ESC: esc_next = 1'b1;
                    wtr_pkg::CODE_LF: begin
                        start.go = 1'b1;
                        start.pc = mode_reg ? wtr_pkg::PC_PASS : wtr_pkg::PC_PAR;
                    end
                    wtr_pkg::CODE_EOD, wtr_pkg::CODE_CR,
                    wtr_pkg::CODE_SOFT_CR, wtr_pkg::CODE_FILL: ;
                    wtr_pkg::CHAR_LBRACE, wtr_pkg::CHAR_RBRACE,
                    wtr_pkg::CHAR_BSLASH: begin
                        start.go = !mode_reg;
                        start.pc = wtr_pkg::PC_ESC;
                    end
                    default: start.go = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            esc_reg   <= 1'b0;
            flags_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_plain_text_mode;
            end
            esc_reg   <= esc_next;
            flags_reg <= flags_next;
        end
    end

    wtr_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (start),
        .flags          (flags_reg),
        .busy           (busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_has_byte     (m_has_byte),
        .m_unknown_code (m_unknown_code),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

// ----- sv/wtr_seq.sv -----
// ----------------------------------------------------------------------------
// wtr_seq
// Microcode sequencer: steps through the ROM program and drives the result
// register: one output byte per step when not stalled; flag tests skip ahead.
// ----------------------------------------------------------------------------
module wtr_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  wtr_pkg::seq_start_t start,
    input  logic [5:0]          flags,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_has_byte,
    output logic                m_unknown_code,
    output logic                m_last_of_run
);

    logic                      busy_reg, busy_next;
    logic [wtr_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      valid_reg, valid_next;
    logic [7:0]                ob_reg, ob_next;
    logic                      hb_reg, hb_next;
    logic                      uk_reg, uk_next;
    logic                      last_reg, last_next;
    wtr_pkg::uword_t           uw;
    logic                      slot_free;

    assign uw        = wtr_pkg::uc_rom(pc_reg);
    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        byte_next  = byte_reg;
        valid_next = valid_reg;
        ob_next    = ob_reg;
        hb_next    = hb_reg;
        uk_next    = uk_reg;
        last_next  = last_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (start.go) begin
            busy_next = 1'b1;
            pc_next   = start.pc;
            byte_next = start.in_byte;
        end else if (busy_reg && slot_free) begin
            if (uw.test_en && !flags[uw.test_bit]) begin
                pc_next = uw.target;
            end else begin
                valid_next = 1'b1;
                last_next  = uw.last;
                unique case (uw.src)
                    wtr_pkg::SRC_LIT: begin
                        ob_next = uw.lit;
                        hb_next = 1'b1;
                        uk_next = 1'b0;
                    end
                    wtr_pkg::SRC_BYTE: begin
                        ob_next = byte_reg;
                        hb_next = 1'b1;
                        uk_next = 1'b0;
                    end
                    default: begin
                        ob_next = 8'h00;
                        hb_next = 1'b0;
                        uk_next = 1'b1;
                    end
                endcase
                if (uw.last) begin
                    busy_next = 1'b0;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            pc_reg    <= '0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            pc_reg    <= pc_next;
        end
        byte_reg <= byte_next;
        ob_reg   <= ob_next;
        hb_reg   <= hb_next;
        uk_reg   <= uk_next;
        last_reg <= last_next;
    end

    assign busy           = busy_reg;
    assign m_valid        = valid_reg;
    assign m_out_byte     = ob_reg;
    assign m_has_byte     = hb_reg;
    assign m_unknown_code = uk_reg;
    assign m_last_of_run  = last_reg;

endmodule

// ----- verif/wordproc_to_rtf_byte_converter_test.sv -----
// ----------------------------------------------------------------------------
// wordproc_to_rtf_byte_converter_test
// Feeds document bytes through the converter in RTF and plain text mode and
// checks every output transfer against a byte-level prediction of the markup.
// ----------------------------------------------------------------------------
module wordproc_to_rtf_byte_converter_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 250;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       unknown_code;
        logic       last_of_run;
    } conv_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_plain_text_mode = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic       m_unknown_code;
    logic       m_last_of_run;

    // predictor state
    logic       plain_mode = 1'b0;
    logic       escape_armed = 1'b0;
    logic [5:0] fmt_flags = '0;

    logic [7:0]   doc_bytes[$];
    logic [7:0]   run_chars[$];
    conv_result_t predicted_output[$];
    int           queued_count = 0;
    int           accepted_count = 0;
    int           result_count = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_count = 0;
    int stall_mode = 0;
    int mode_left = 0;
    logic hold_off_kick = 1'b0;

    wordproc_to_rtf_byte_converter i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_plain_text_mode (cfg_plain_text_mode),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_in_byte           (s_in_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_byte          (m_out_byte),
        .m_has_byte          (m_has_byte),
        .m_unknown_code      (m_unknown_code),
        .m_last_of_run       (m_last_of_run)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) run_chars.push_back(s[i]);
    endtask

    // Works out the output bytes of one document byte and updates the state.
    task automatic convert_byte(input logic [7:0] b);
        conv_result_t r;
        int flag_pos;
        flag_pos = -1;
        run_chars.delete();
        if (escape_armed) begin
            escape_armed = 1'b0;
            if (!plain_mode) begin
                case (b)
                    wtr_pkg::CODE_BOLD:    flag_pos = wtr_pkg::FLG_BOLD;
                    wtr_pkg::CODE_ITALIC:  flag_pos = wtr_pkg::FLG_ITALIC;
                    wtr_pkg::CODE_ULINE:   flag_pos = wtr_pkg::FLG_ULINE;
                    wtr_pkg::CODE_SUB:     flag_pos = wtr_pkg::FLG_SUB;
                    wtr_pkg::CODE_SUPER:   flag_pos = wtr_pkg::FLG_SUPER;
                    wtr_pkg::CODE_LARGE:   flag_pos = wtr_pkg::FLG_LARGE;
                    wtr_pkg::CODE_SOFT_SP: ;
                    default: begin
                        r.out_byte     = 8'h00;
                        r.has_byte     = 1'b0;
                        r.unknown_code = 1'b1;
                        r.last_of_run  = 1'b1;
                        predicted_output.push_back(r);
                    end
                endcase
                if (flag_pos >= 0) begin
                    fmt_flags[flag_pos] = ~fmt_flags[flag_pos];
                    add_text("\\plain");
                    if (fmt_flags[wtr_pkg::FLG_BOLD])   add_text("\\b");
                    if (fmt_flags[wtr_pkg::FLG_ITALIC]) add_text("\\i");
                    if (fmt_flags[wtr_pkg::FLG_ULINE])  add_text("\\ul");
                    if (fmt_flags[wtr_pkg::FLG_SUB])    add_text("\\dn");
                    if (fmt_flags[wtr_pkg::FLG_SUPER])  add_text("\\up");
                    if (fmt_flags[wtr_pkg::FLG_LARGE])  add_text("\\fs28 ");
                    else                                add_text("\\fs24 ");
                end
            end
        end else begin
            case (b)
                wtr_pkg::CODE_ESC: escape_armed = 1'b1;
                wtr_pkg::CODE_LF: begin
                    if (plain_mode) run_chars.push_back(wtr_pkg::CODE_LF);
                    else            add_text("\\par\\fs24 ");
                end
                wtr_pkg::CODE_CR, wtr_pkg::CODE_EOD, wtr_pkg::CODE_SOFT_CR,
                wtr_pkg::CODE_FILL: ;
                wtr_pkg::CHAR_LBRACE, wtr_pkg::CHAR_RBRACE, wtr_pkg::CHAR_BSLASH: begin
                    if (!plain_mode) begin
                        run_chars.push_back(wtr_pkg::CHAR_BSLASH);
                        run_chars.push_back(b);
                    end
                end
                default: run_chars.push_back(b);
            endcase
        end
        foreach (run_chars[i]) begin
            r.out_byte     = run_chars[i];
            r.has_byte     = 1'b1;
            r.unknown_code = 1'b0;
            r.last_of_run  = (i == run_chars.size() - 1);
            predicted_output.push_back(r);
        end
    endtask

    task automatic check_result();
        conv_result_t r;
        if (predicted_output.size() == 0) begin
            flag_error($sformatf("result %0d: unexpected transfer, out_byte %02h",
                                 result_count, m_out_byte));
        end else begin
            r = predicted_output.pop_front();
            if (m_out_byte !== r.out_byte)
                flag_error($sformatf("result %0d: out_byte %02h, expected %02h",
                                     result_count, m_out_byte, r.out_byte));
            if (m_has_byte !== r.has_byte)
                flag_error($sformatf("result %0d: has_byte %b, expected %b",
                                     result_count, m_has_byte, r.has_byte));
            if (m_unknown_code !== r.unknown_code)
                flag_error($sformatf("result %0d: unknown_code %b, expected %b",
                                     result_count, m_unknown_code, r.unknown_code));
            if (m_last_of_run !== r.last_of_run)
                flag_error($sformatf("result %0d: last_of_run %b, expected %b",
                                     result_count, m_last_of_run, r.last_of_run));
        end
        result_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        doc_bytes.push_back(b);
        queued_count++;
    endtask

    task automatic write_mode(input logic mode);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_plain_text_mode <= mode;
        do @(posedge aclk); while (!cfg_ready);
        plain_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    // Wait until every byte is taken and every predicted result has come out;
    // escapes and dropped codes give no result, so a settle wait follows.
    task automatic wait_idle();
        while (accepted_count != queued_count || predicted_output.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed text with format escapes, plus some noise.
    task automatic queue_random_doc(input int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_byte(8'($urandom_range(8'h20, 8'h7E)));
                sent += 1;
            end else if (pick < 62) begin
                send_byte(wtr_pkg::CODE_ESC);
                case ($urandom_range(0, 6))
                    0: send_byte(wtr_pkg::CODE_BOLD);
                    1: send_byte(wtr_pkg::CODE_ITALIC);
                    2: send_byte(wtr_pkg::CODE_ULINE);
                    3: send_byte(wtr_pkg::CODE_SUB);
                    4: send_byte(wtr_pkg::CODE_SUPER);
                    5: send_byte(wtr_pkg::CODE_LARGE);
                    default: send_byte(wtr_pkg::CODE_SOFT_SP);
                endcase
                sent += 2;
            end else if (pick < 69) begin
                send_byte(wtr_pkg::CODE_LF);
                sent += 1;
            end else if (pick < 74) begin
                case ($urandom_range(0, 2))
                    0: send_byte(wtr_pkg::CHAR_LBRACE);
                    1: send_byte(wtr_pkg::CHAR_RBRACE);
                    default: send_byte(wtr_pkg::CHAR_BSLASH);
                endcase
                sent += 1;
            end else if (pick < 79) begin
                case ($urandom_range(0, 3))
                    0: send_byte(wtr_pkg::CODE_CR);
                    1: send_byte(wtr_pkg::CODE_EOD);
                    2: send_byte(wtr_pkg::CODE_SOFT_CR);
                    default: send_byte(wtr_pkg::CODE_FILL);
                endcase
                sent += 1;
            end else if (pick < 85) begin
                send_byte(wtr_pkg::CODE_ESC);
                send_byte(8'($urandom_range(0, 255)));
                sent += 2;
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                convert_byte(s_in_byte);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (doc_bytes.size() > 0) begin
                    s_in_byte <= doc_bytes.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 2);
                            2: gap_left = $urandom_range(3, 9);
                            default: gap_left = 0;
                        endcase
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches between modes; one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_count = 0;
            stall_mode = 0;
            mode_left = 0;
        end else begin
            if (m_valid && m_ready) check_result();
            if (hold_off_kick) hold_count = HOLD_OFF_CYCLES;
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            if (hold_count > 0) begin
                hold_count--;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [7:0] rtf_directed[$];
        logic [7:0] text_directed[$];
        rtf_directed = '{8'h00, wtr_pkg::CODE_FILL, wtr_pkg::CHAR_LBRACE,
                         wtr_pkg::CHAR_RBRACE, wtr_pkg::CHAR_BSLASH,
                         wtr_pkg::CODE_LF, wtr_pkg::CODE_CR, wtr_pkg::CODE_EOD,
                         wtr_pkg::CODE_SOFT_CR,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_BOLD,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_ITALIC,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_ULINE,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_SUB,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_SUPER,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_LARGE,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_SOFT_SP,
                         wtr_pkg::CODE_ESC, wtr_pkg::CODE_ESC};
        // ends with an armed escape that carries across the mode change
        text_directed = '{wtr_pkg::CHAR_BSLASH, wtr_pkg::CHAR_LBRACE, wtr_pkg::CODE_LF,
                          wtr_pkg::CODE_ESC, wtr_pkg::CODE_BOLD,
                          8'h41, wtr_pkg::CODE_ESC};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        write_mode(1'b0);
        foreach (rtf_directed[i]) send_byte(rtf_directed[i]);
        wait_idle();

        write_mode(1'b1);
        foreach (text_directed[i]) send_byte(text_directed[i]);
        wait_idle();

        // receiver holds off while the sender keeps offering bytes
        write_mode(1'b0);
        queue_random_doc(60);
        @(posedge aclk);
        hold_off_kick <= 1'b1;
        @(posedge aclk);
        hold_off_kick <= 1'b0;
        wait_idle();

        write_mode(1'b1);
        queue_random_doc(30);
        wait_idle();

        write_mode(1'b0);
        queue_random_doc(35);
        wait_idle();

        write_mode(1'b1);
        queue_random_doc(12);
        wait_idle();

        write_mode(1'b0);
        queue_random_doc(12);
        wait_idle();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
